@@ rtl/readout_hit_record_decoder_unit_macros.svh @@
// Assertion macros used by the top level of the hit record decoder RTL.
`ifndef READOUT_HIT_RECORD_DECODER_UNIT_MACROS_SVH
`define READOUT_HIT_RECORD_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RHD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("hit record decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("hit record decoder check failed");

`else

`define RHD_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define RHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/rhd_pkg.sv @@
// Types, constants and helper functions of the hit record decoder.
package rhd_pkg;

	localparam int QUOT_W     = 18;
	localparam int DIVIDEND_W = 23;
	localparam int DIVISOR_W  = 21;
	localparam int SCALED_W   = 23;

	localparam logic [1:0] REG_BX_ZERO_OFFSET = 2'd0;
	localparam logic [1:0] REG_BX_LENGTH      = 2'd1;
	localparam logic [1:0] REG_ADC_THRESHOLD  = 2'd2;

	localparam logic [23:0] RST_BX_ZERO_OFFSET = 24'd8750;
	localparam logic [15:0] RST_BX_LENGTH      = 16'd160;
	localparam logic [9:0]  RST_ADC_THRESHOLD  = 10'd600;

	localparam logic [5:0]  REF_CHAN       = 6'd36;
	localparam logic [1:0]  REF_GROUP      = 2'd3;
	localparam logic [3:0]  REF_ID         = 4'd0;
	localparam logic [3:0]  CHAN_PER_GROUP = 4'd12;
	localparam logic [9:0]  ADC_FULL       = 10'd1023;
	localparam logic [6:0]  TDC_SCALE      = 7'd100;
	localparam logic [4:0]  BX_UNIT        = 5'd25;

	typedef struct packed {
		logic [7:0] rec_byte0;
		logic [7:0] rec_byte1;
		logic [7:0] rec_byte2;
		logic [7:0] rec_byte3;
		logic [7:0] rec_byte5;
	} hit_t;

	typedef struct packed {
		logic [5:0]        chan_number;
		logic              chan_valid;
		logic              high_gain;
		logic [9:0]        adc_value;
		logic [15:0]       tdc_value;
		logic [QUOT_W-1:0] bx_index;
		logic              before_zero;
		logic              above_cut;
	} res_t;

	typedef struct packed {
		logic [23:0] bx_zero_offset;
		logic [15:0] bx_length;
		logic [9:0]  adc_threshold;
	} cfg_t;

	// One beat travelling down the divider chain: decoded fields, the partial
	// remainder, and a word that shifts dividend bits out and quotient bits in.
	typedef struct packed {
		res_t                 res;
		logic [DIVISOR_W-1:0] rem;
		logic [QUOT_W-1:0]    dq;
	} cell_t;

	function automatic logic [15:0] gray_to_bin(input logic [15:0] g);
		logic [15:0] b;
		for (int i = 0; i < 16; i++) begin
			b[i] = ^(g >> i);
		end
		return b;
	endfunction

endpackage

@@ rtl/readout_hit_record_decoder_unit.sv @@
// Top level of the hit record decoder: registers, front stages and divider chain.
//
// The decoder takes one hit record per clock cycle, every cycle, and never
// raises busy. Each record comes out as one result beat, marked by done for
// a single cycle; results leave in the order the records came in. The
// receiver has no way to stall the block, so it must take every beat in the
// cycle it is shown. The path runs through two front stages (field decode,
// then TDC scaling and the offset subtraction), a row of 18 division cells
// that each settle one bit of the bunch crossing index, and the output
// register. The registers on the APB port may only be written while no
// record is in flight.

`include "readout_hit_record_decoder_unit_macros.svh"

module readout_hit_record_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rhd_pkg::hit_t      hit,
	output logic               done,
	output rhd_pkg::res_t      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int NCELL   = rhd_pkg::QUOT_W;
	localparam int LATENCY = NCELL + 3;

	rhd_pkg::cfg_t                   cfg_q;
	logic [rhd_pkg::DIVISOR_W-1:0]   divisor_q;
	logic                            wr_en;
	logic [1:0]                      reg_idx;

	logic                            chain_vld  [0:NCELL];
	rhd_pkg::cell_t                  chain_data [0:NCELL];

	logic                            done_q;
	rhd_pkg::res_t                   result_q;
	rhd_pkg::res_t                   res_d;

	// The pipeline never stalls, so a new record is welcome in every cycle.
	assign busy   = 1'b0;
	assign pready = 1'b1;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bx_zero_offset <= rhd_pkg::RST_BX_ZERO_OFFSET;
			cfg_q.bx_length      <= rhd_pkg::RST_BX_LENGTH;
			cfg_q.adc_threshold  <= rhd_pkg::RST_ADC_THRESHOLD;
		end else if (wr_en) begin
			case (reg_idx)
				rhd_pkg::REG_BX_ZERO_OFFSET: cfg_q.bx_zero_offset <= pwdata[23:0];
				rhd_pkg::REG_BX_LENGTH:      cfg_q.bx_length      <= pwdata[15:0];
				rhd_pkg::REG_ADC_THRESHOLD:  cfg_q.adc_threshold  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rhd_pkg::REG_BX_ZERO_OFFSET: prdata = {8'd0, cfg_q.bx_zero_offset};
			rhd_pkg::REG_BX_LENGTH:      prdata = {16'd0, cfg_q.bx_length};
			rhd_pkg::REG_ADC_THRESHOLD:  prdata = {22'd0, cfg_q.adc_threshold};
			default:                     prdata = 32'd0;
		endcase
	end

	// The divisor is the bunch crossing length times 25. It is registered so
	// the cells see a plain compare; a record passes both front stage registers
	// before it reaches the first cell, by which time this register has settled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= rhd_pkg::DIVISOR_W'(rhd_pkg::RST_BX_LENGTH)
				* rhd_pkg::DIVISOR_W'(rhd_pkg::BX_UNIT);
		end else begin
			divisor_q <= rhd_pkg::DIVISOR_W'(cfg_q.bx_length)
				* rhd_pkg::DIVISOR_W'(rhd_pkg::BX_UNIT);
		end
	end

	rhd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (start && !busy),
		.hit       (hit),
		.cfg       (cfg_q),
		.out_valid (chain_vld[0]),
		.out_data  (chain_data[0])
	);

	// Each cell shifts in one dividend bit and settles one quotient bit, from
	// the most significant down. With a zero divisor every step succeeds and
	// the quotient comes out all ones, which is the saturated index.
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		rhd_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (divisor_q),
			.in_valid  (chain_vld[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_vld[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_vld[NCELL];
		end
	end

	// A hit before bunch crossing zero reports index zero.
	always_comb begin
		res_d          = chain_data[NCELL].res;
		res_d.bx_index = chain_data[NCELL].res.before_zero ? '0 : chain_data[NCELL].dq;
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

	`RHD_ASSERT_NOW(a_done_latency, clk, arst_n, done, $past(start, LATENCY))
	`RHD_ASSERT_NOW(a_early_zero, clk, arst_n, done && result.before_zero, result.bx_index == '0)
	`RHD_ASSERT_NOW(a_cut_gain, clk, arst_n, done && result.above_cut, result.high_gain)
	`RHD_ASSERT_NEXT(a_cell_flow, clk, arst_n, chain_vld[0], chain_vld[1])

endmodule

@@ rtl/rhd_front.sv @@
// Front stages: field decode, TDC scaling and offset subtraction.
module rhd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  rhd_pkg::hit_t       hit,
	input  rhd_pkg::cfg_t       cfg,
	output logic                out_valid,
	output rhd_pkg::cell_t      out_data
);

	logic                        vld_s1;
	rhd_pkg::res_t               dec_s1;
	rhd_pkg::res_t               dec;
	logic [3:0]                  id;
	logic [1:0]                  grp;
	logic [rhd_pkg::SCALED_W-1:0] scaled;
	logic [24:0]                 diff_full;
	rhd_pkg::cell_t              cell_d;

	always_comb begin
		id  = hit.rec_byte1[3:0];
		grp = hit.rec_byte1[5:4];
		dec = '0;
		if (grp == rhd_pkg::REF_GROUP && id == rhd_pkg::REF_ID) begin
			dec.chan_number = rhd_pkg::REF_CHAN;
			dec.chan_valid  = 1'b1;
		end else if (id < rhd_pkg::CHAN_PER_GROUP) begin
			dec.chan_number = 6'({grp, 3'b000}) + 6'({grp, 2'b00}) + 6'(id);
			dec.chan_valid  = 1'b1;
		end
		dec.high_gain = ~hit.rec_byte0[7];
		dec.adc_value = rhd_pkg::ADC_FULL - {hit.rec_byte0[5:0], hit.rec_byte3[7:4]};
		dec.tdc_value = rhd_pkg::gray_to_bin({hit.rec_byte2, hit.rec_byte5});
		dec.above_cut = dec.high_gain && (dec.adc_value > cfg.adc_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= dec;
	end

	// The scaled time is compared with the offset through one subtraction; its
	// borrow marks a hit before bunch crossing zero.
	always_comb begin
		scaled    = rhd_pkg::SCALED_W'(dec_s1.tdc_value)
			* rhd_pkg::SCALED_W'(rhd_pkg::TDC_SCALE);
		diff_full = {2'b00, scaled} - {1'b0, cfg.bx_zero_offset};
		cell_d                 = '0;
		cell_d.res             = dec_s1;
		cell_d.res.before_zero = diff_full[24];
		cell_d.rem             = rhd_pkg::DIVISOR_W'(
			diff_full[rhd_pkg::DIVIDEND_W-1:rhd_pkg::QUOT_W]);
		cell_d.dq              = diff_full[rhd_pkg::QUOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= cell_d;
	end

endmodule

@@ rtl/rhd_div_cell.sv @@
// One restoring division step: produces one quotient bit per beat.
module rhd_div_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rhd_pkg::DIVISOR_W-1:0]  divisor,
	input  logic                           in_valid,
	input  rhd_pkg::cell_t                 in_data,
	output logic                           out_valid,
	output rhd_pkg::cell_t                 out_data
);

	logic [rhd_pkg::DIVISOR_W:0]   trial;
	logic [rhd_pkg::DIVISOR_W:0]   sub;
	logic                          ge;
	rhd_pkg::cell_t                nxt;

	always_comb begin
		trial   = {in_data.rem, in_data.dq[rhd_pkg::QUOT_W-1]};
		sub     = trial - {1'b0, divisor};
		ge      = trial >= {1'b0, divisor};
		nxt     = in_data;
		nxt.rem = ge ? sub[rhd_pkg::DIVISOR_W-1:0] : trial[rhd_pkg::DIVISOR_W-1:0];
		nxt.dq  = {in_data.dq[rhd_pkg::QUOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

@@ tb/readout_hit_record_decoder_unit_test.sv @@
// Self-checking testbench of the hit record decoder: stimulus, register setup and result checks.
module readout_hit_record_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// After the queue has drained, the tail keeps the clock running for longer
	// than a record takes to come out, so a stray late beat is caught.
	localparam int          HALF_PERIOD  = 6;
	localparam int          RESET_CYCLES = 8;
	localparam int          DRAIN_CYCLES = 45;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned BX_MAX       = 262143;

	// Register slot behind the last one. Writes to it must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Holds a copy of the three registers, works out the decoded fields of
	// every record that the block takes, and compares the beats that come
	// back against them in order.
	class hit_scoreboard;
		logic [23:0]   zero_offset;
		logic [15:0]   bx_len;
		logic [9:0]    adc_cut;
		rhd_pkg::res_t expected_q[$];
		int unsigned   n_hits;
		int unsigned   n_results;
		int unsigned   n_mismatch;
		int unsigned   n_ref;
		int unsigned   n_bad_chan;
		int unsigned   n_early;
		int unsigned   n_cut;
		int unsigned   n_sat;

		function new();
			zero_offset = rhd_pkg::RST_BX_ZERO_OFFSET;
			bx_len      = rhd_pkg::RST_BX_LENGTH;
			adc_cut     = rhd_pkg::RST_ADC_THRESHOLD;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				rhd_pkg::REG_BX_ZERO_OFFSET: zero_offset = value[23:0];
				rhd_pkg::REG_BX_LENGTH:      bx_len      = value[15:0];
				rhd_pkg::REG_ADC_THRESHOLD:  adc_cut     = value[9:0];
				default: ;
			endcase
		endfunction

		// Each binary bit is the parity of all Gray bits at and above it.
		function logic [15:0] tdc_binary(logic [15:0] g);
			logic [15:0] b;
			b[15] = g[15];
			for (int i = 14; i >= 0; i--) begin
				b[i] = b[i + 1] ^ g[i];
			end
			return b;
		endfunction

		function rhd_pkg::res_t decode(rhd_pkg::hit_t h);
			logic [3:0]    id;
			logic [1:0]    grp;
			logic [9:0]    raw;
			int unsigned   scaled;
			int unsigned   divisor;
			int unsigned   quo;
			rhd_pkg::res_t r;
			r   = '0;
			id  = h.rec_byte1[3:0];
			grp = h.rec_byte1[5:4];
			if (grp == rhd_pkg::REF_GROUP && id == rhd_pkg::REF_ID) begin
				r.chan_number = rhd_pkg::REF_CHAN;
				r.chan_valid  = 1'b1;
			end else if (id < rhd_pkg::CHAN_PER_GROUP) begin
				r.chan_number = 6'(int'(rhd_pkg::CHAN_PER_GROUP) * int'(grp) + int'(id));
				r.chan_valid  = 1'b1;
			end
			r.high_gain = ~h.rec_byte0[7];
			raw         = {h.rec_byte0[5:0], h.rec_byte3[7:4]};
			r.adc_value = rhd_pkg::ADC_FULL - raw;
			r.tdc_value = tdc_binary({h.rec_byte2, h.rec_byte5});
			scaled      = int'(r.tdc_value) * 100;
			if (scaled < zero_offset) begin
				r.before_zero = 1'b1;
			end else begin
				divisor = int'(bx_len) * 25;
				quo     = (divisor == 0) ? BX_MAX : (scaled - zero_offset) / divisor;
				if (quo > BX_MAX) begin
					quo = BX_MAX;
				end
				r.bx_index = quo[17:0];
			end
			r.above_cut = r.high_gain && (r.adc_value > adc_cut);
			return r;
		endfunction

		function void note_hit(rhd_pkg::hit_t h);
			rhd_pkg::res_t r;
			r = decode(h);
			expected_q.push_back(r);
			n_hits++;
			if (h.rec_byte1[5:0] == {rhd_pkg::REF_GROUP, rhd_pkg::REF_ID}) begin
				n_ref++;
			end
			if (!r.chan_valid) begin
				n_bad_chan++;
			end
			if (r.before_zero) begin
				n_early++;
			end else if (r.bx_index == BX_MAX[17:0]) begin
				n_sat++;
			end
			if (r.above_cut) begin
				n_cut++;
			end
		endfunction

		function void flag(string msg);
			n_mismatch++;
			if (n_mismatch <= 10) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endfunction

		function void cmp_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				flag($sformatf("result %0d field %s expected %0d, got %0d",
					n_results, name, want, got));
			end
		endfunction

		function void check_result(rhd_pkg::res_t got);
			rhd_pkg::res_t want;
			if (expected_q.size() == 0) begin
				flag("result beat arrived with no record waiting for it");
				return;
			end
			want = expected_q.pop_front();
			cmp_field("chan_number", want.chan_number, got.chan_number);
			cmp_field("chan_valid", want.chan_valid, got.chan_valid);
			cmp_field("high_gain", want.high_gain, got.high_gain);
			cmp_field("adc_value", want.adc_value, got.adc_value);
			cmp_field("tdc_value", want.tdc_value, got.tdc_value);
			cmp_field("bx_index", want.bx_index, got.bx_index);
			cmp_field("before_zero", want.before_zero, got.before_zero);
			cmp_field("above_cut", want.above_cut, got.above_cut);
			n_results++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	rhd_pkg::hit_t hit;
	logic          done;
	rhd_pkg::res_t result;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [3:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	hit_scoreboard sb;
	int unsigned   cycle_count;
	int unsigned   n_settings;

	readout_hit_record_decoder_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.hit     (hit),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Every result beat is shown for one cycle and cannot be held off, so it
	// is taken at the edge that closes that cycle. Outputs only move on
	// nonblocking updates, so the values read here are the ones before the edge.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
		end
	end

	// Watchdog: ends the run as a failure once the cycle limit is reached.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, sb.pending());
			$display("readout_hit_record_decoder_unit_test: FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] gray_of(logic [15:0] b);
		return b ^ (b >> 1);
	endfunction

	// Builds a record from the decoded values wanted. The junk flag fills the
	// bits the decoder must ignore with ones.
	function automatic rhd_pkg::hit_t make_hit(logic hg, logic [9:0] adc, logic [3:0] id,
		logic [1:0] grp, logic [15:0] tdc, logic junk);
		rhd_pkg::hit_t h;
		logic [9:0]    raw;
		logic [15:0]   g;
		raw          = rhd_pkg::ADC_FULL - adc;
		g            = gray_of(tdc);
		h.rec_byte0  = {~hg, junk, raw[9:4]};
		h.rec_byte1  = {junk, junk, grp, id};
		h.rec_byte2  = g[15:8];
		h.rec_byte3  = {raw[3:0], {4{junk}}};
		h.rec_byte5  = g[7:0];
		return h;
	endfunction

	// Random record. Most bits are free, but part of the records are steered
	// onto the reference channel, onto the TDC values around bunch crossing
	// zero, or onto ADC values around the cut, since plain random bytes
	// would rarely land there.
	function automatic rhd_pkg::hit_t random_hit();
		rhd_pkg::hit_t h;
		int unsigned   pick;
		int unsigned   tdc_bin;
		logic [15:0]   g;
		logic [9:0]    adc;
		logic [9:0]    raw;
		h.rec_byte0 = 8'($urandom);
		h.rec_byte1 = 8'($urandom);
		h.rec_byte2 = 8'($urandom);
		h.rec_byte3 = 8'($urandom);
		h.rec_byte5 = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			h.rec_byte1[5:0] = {rhd_pkg::REF_GROUP, rhd_pkg::REF_ID};
		end else if (pick < 30) begin
			tdc_bin = sb.zero_offset / 100 + $urandom_range(0, 2);
			tdc_bin = (tdc_bin == 0) ? 0 : tdc_bin - 1;
			if (tdc_bin > 65535) begin
				tdc_bin = 65535;
			end
			g           = gray_of(tdc_bin[15:0]);
			h.rec_byte2 = g[15:8];
			h.rec_byte5 = g[7:0];
		end else if (pick < 45) begin
			adc              = sb.adc_cut + 10'($urandom_range(0, 2)) - 10'd1;
			raw              = rhd_pkg::ADC_FULL - adc;
			h.rec_byte0[7]   = 1'b0;
			h.rec_byte0[5:0] = raw[9:4];
			h.rec_byte3[7:4] = raw[3:0];
		end
		return h;
	endfunction

	// One record beat. A gap of zero keeps start high from the previous beat,
	// so records go in back to back. The record counts as taken at the first
	// edge at which busy was low.
	task automatic send_hit(input rhd_pkg::hit_t h, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		hit   <= h;
		do @(posedge clk); while (busy);
		sb.note_hit(h);
	endtask

	// Random records in blocks of twenty. About one block in four runs with
	// no gaps at all, the others draw a fresh gap for every record.
	task automatic run_random(input int n);
		bit          burst;
		int unsigned gap;
		burst = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
			end
			gap = burst ? 0 : $urandom_range(0, 14);
			send_hit(random_hit(), gap);
		end
		start <= 1'b0;
	endtask

	// Register writes are only safe with no record in flight. Every record
	// gives exactly one result, so an empty queue means the pipe is empty.
	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// APB write followed straight away by a read of the same register, with
	// psel held high across the two transfers; the unused slot is only written.
	// The read value is compared over the register's width only.
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] mask;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		if (idx == REG_SPARE) begin
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
		end else begin
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			rd      = prdata;
			psel    <= 1'b0;
			penable <= 1'b0;
			case (idx)
				rhd_pkg::REG_BX_ZERO_OFFSET: mask = 32'h00FF_FFFF;
				rhd_pkg::REG_BX_LENGTH:      mask = 32'h0000_FFFF;
				default:                     mask = 32'h0000_03FF;
			endcase
			if ((rd & mask) != (value & mask)) begin
				sb.flag($sformatf("register %0d read back 0x%0h, expected 0x%0h",
					idx, rd & mask, value & mask));
			end
		end
	endtask

	// Writes all three registers. The bits above each register's width carry
	// random junk, which the block has to drop.
	task automatic set_config(input logic [23:0] offset, input logic [15:0] len,
		input logic [9:0] cut);
		logic [31:0] v;
		wait_idle();
		v = $urandom;
		v[23:0] = offset;
		apb_write(rhd_pkg::REG_BX_ZERO_OFFSET, v);
		v = $urandom;
		v[15:0] = len;
		apb_write(rhd_pkg::REG_BX_LENGTH, v);
		v = $urandom;
		v[9:0] = cut;
		apb_write(rhd_pkg::REG_ADC_THRESHOLD, v);
		n_settings++;
	endtask

	// Directed records under the reset register values (offset 8750, length
	// 160, cut 600): raw all-zero and all-one bytes, the reference channel with
	// and without junk in the ignored bits, the highest decodable ids, ids of
	// 12 and above, the TDC on either side of bunch crossing zero and at its
	// maximum, and the ADC at the cut, just above it and in low gain.
	task automatic run_directed();
		rhd_pkg::hit_t dir_q[$];
		dir_q.push_back('0);
		dir_q.push_back('1);
		dir_q.push_back(make_hit(1'b0, 10'd0, 4'd0, 2'd0, 16'd0, 1'b0));
		dir_q.push_back(make_hit(1'b1, 10'd700, rhd_pkg::REF_ID, rhd_pkg::REF_GROUP,
			16'd1000, 1'b0));
		dir_q.push_back(make_hit(1'b1, 10'd700, rhd_pkg::REF_ID, rhd_pkg::REF_GROUP,
			16'd1000, 1'b1));
		dir_q.push_back(make_hit(1'b0, 10'd10, 4'd11, 2'd2, 16'd5000, 1'b0));
		dir_q.push_back(make_hit(1'b1, 10'd500, 4'd11, 2'd3, 16'd20000, 1'b0));
		dir_q.push_back(make_hit(1'b1, 10'd1023, 4'd12, 2'd0, 16'd65535, 1'b1));
		dir_q.push_back(make_hit(1'b1, 10'd601, 4'd15, 2'd3, 16'd88, 1'b0));
		dir_q.push_back(make_hit(1'b1, 10'd600, 4'd0, 2'd0, 16'd87, 1'b0));
		dir_q.push_back(make_hit(1'b1, 10'd599, 4'd3, 2'd1, 16'd88, 1'b1));
		dir_q.push_back(make_hit(1'b0, 10'd1023, 4'd5, 2'd1, 16'd30000, 1'b1));
		dir_q.push_back(make_hit(1'b1, 10'd0, 4'd13, 2'd2, 16'd65535, 1'b0));
		dir_q.push_back(make_hit(1'b0, 10'd512, 4'd14, 2'd1, 16'd43690, 1'b1));
		foreach (dir_q[i]) begin
			send_hit(dir_q[i], (i % 3 == 0) ? 0 : $urandom_range(0, 14));
		end
		start <= 1'b0;
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		hit         = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		cycle_count = 0;
		n_settings  = 1;
		sb          = new();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first, so the defaults of the registers are seen.
		run_directed();
		run_random(100);

		// Smallest settings: no offset, the shortest nonzero crossing and no cut.
		set_config(24'd0, 16'd1, 10'd0);
		run_random(80);

		// Largest settings: every scaled TDC lies before bunch crossing zero.
		set_config(24'hFF_FFFF, 16'hFFFF, 10'h3FF);
		run_random(60);

		// Offset within the TDC range and a short crossing length.
		set_config(24'($urandom_range(0, 6553500)), 16'($urandom_range(1, 400)),
			10'($urandom));
		run_random(100);

		// A crossing length of zero: the index saturates after bunch zero.
		set_config(24'($urandom_range(0, 6553500)), 16'd0, 10'd512);
		run_random(40);

		// Back to the reset values, with a write to the unused slot on top.
		set_config(rhd_pkg::RST_BX_ZERO_OFFSET, rhd_pkg::RST_BX_LENGTH,
			rhd_pkg::RST_ADC_THRESHOLD);
		apb_write(REG_SPARE, $urandom);
		run_random(100);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("coverage: %0d records, %0d results checked under %0d register settings",
			sb.n_hits, sb.n_results, n_settings);
		$display("  reference %0d, undecodable %0d, early %0d, saturated %0d, cut %0d",
			sb.n_ref, sb.n_bad_chan, sb.n_early, sb.n_sat, sb.n_cut);
		if (sb.n_mismatch == 0 && sb.pending() == 0) begin
			$display("readout_hit_record_decoder_unit_test: PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.n_mismatch, sb.pending());
			$display("readout_hit_record_decoder_unit_test: FAIL");
		end
		$finish;
	end

endmodule
